>>> rtl/core/acm_pkg.sv
`timescale 1ns / 1ps

package acm_pkg;

    localparam int PROG_DEPTH_DEF = 128;
    localparam int DATA_DEPTH_DEF = 16;
    localparam int WORD_BITS_DEF  = 32;

    // item kinds
    localparam logic KIND_PROG = 1'b0;
    localparam logic KIND_EXEC = 1'b1;

    // opcodes as stored in instruction memory
    localparam logic [7:0] OP_LOAD  = 8'd1;
    localparam logic [7:0] OP_ADD   = 8'd2;
    localparam logic [7:0] OP_STORE = 8'd3;
    localparam logic [7:0] OP_SUB   = 8'd4;
    localparam logic [7:0] OP_IN    = 8'd5;
    localparam logic [7:0] OP_OUT   = 8'd6;
    localparam logic [7:0] OP_HALT  = 8'd7;
    localparam logic [7:0] OP_JMP   = 8'd8;
    localparam logic [7:0] OP_SKIPZ = 8'd9;
    localparam logic [7:0] OP_SKIPG = 8'd10;
    localparam logic [7:0] OP_SKIPL = 8'd11;

    typedef struct packed {
        logic               op_kind;
        logic [6:0]         prog_index;
        logic [7:0]         prog_word;
        logic signed [31:0] in_value;
    } cmd_t;

    typedef struct packed {
        logic [6:0]         pc_now;
        logic signed [31:0] acc_now;
        logic               out_valid;
        logic [3:0]         done_opcode;
        logic               halted_now;
    } rsp_t;

    // side effects decided by the execute unit
    typedef struct packed {
        logic       strobe;
        logic       halt_next;
        logic       st_en;
        logic [3:0] done;
    } alu_flags_t;

endpackage

>>> rtl/core/acm_ram.sv
`timescale 1ns / 1ps

module acm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> rtl/core/acm_dmem.sv
`timescale 1ns / 1ps

module acm_dmem #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [DEPTH-1:0] valid_reg;
    logic             rd_valid_reg;
    logic [WIDTH-1:0] ram_q;

    // entries never stored to read as zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_valid_reg <= valid_reg[rd_addr];
            end
        end
    end

    acm_ram #(
        .WIDTH (WIDTH),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (ram_q)
    );

    assign rd_data = rd_valid_reg ? ram_q : '0;

endmodule

>>> rtl/core/acm_alu.sv
`timescale 1ns / 1ps

module acm_alu import acm_pkg::*; #(
    parameter int PAW       = 7,
    parameter int WORD_BITS = WORD_BITS_DEF
) (
    input  logic                 exec,
    input  logic [7:0]           opc,
    input  logic [7:0]           adr,
    input  logic [PAW-1:0]       pc,
    input  logic [WORD_BITS-1:0] acc,
    input  logic                 halted,
    input  logic [WORD_BITS-1:0] mem_data,
    input  logic signed [31:0]   in_value,
    output logic [PAW-1:0]       pc_next,
    output logic [WORD_BITS-1:0] acc_next,
    output alu_flags_t           flags
);

    logic [PAW-1:0] pc_step;
    logic [PAW-1:0] pc_skip;
    logic           acc_neg;
    logic           acc_zero;

    assign pc_step  = pc + PAW'(2);
    assign pc_skip  = pc + PAW'(4);
    assign acc_neg  = acc[WORD_BITS-1];
    assign acc_zero = (acc == '0);

    always_comb
    begin
        acc_next        = acc;
        pc_next         = pc;
        flags           = '0;
        flags.halt_next = halted;
        if (exec)
        begin
            pc_next = pc_step;
            if (opc >= OP_LOAD && opc <= OP_SKIPL)
            begin
                flags.done = opc[3:0];
            end
            unique case (opc)
                OP_LOAD:  acc_next = mem_data;
                OP_ADD:   acc_next = acc + mem_data;
                OP_STORE: flags.st_en = 1'b1;
                OP_SUB:   acc_next = acc - mem_data;
                OP_IN:    acc_next = WORD_BITS'(in_value);
                OP_OUT:   flags.strobe = 1'b1;
                OP_HALT:  flags.halt_next = 1'b1;
                OP_JMP:   pc_next = PAW'(adr);
                OP_SKIPZ:
                begin
                    if (acc_zero)
                    begin
                        pc_next = pc_skip;
                    end
                end
                OP_SKIPG:
                begin
                    if (!acc_zero && !acc_neg)
                    begin
                        pc_next = pc_skip;
                    end
                end
                OP_SKIPL:
                begin
                    if (acc_neg)
                    begin
                        pc_next = pc_skip;
                    end
                end
                default: ;
            endcase
        end
    end

endmodule

>>> rtl/core/accumulator_cpu_step.sv
`timescale 1ns / 1ps

// Accumulator machine, one item per cmd transfer, one result per rsp transfer.
// cmd carries either a program word (op_kind 0, written to instruction memory
// at prog_index) or a step request (op_kind 1, runs the instruction at PC).
// rsp reports PC, accumulator, OUT strobe, executed opcode and halt status.
// Load the program before stepping; stepping after HALT changes nothing.
// Each item goes through fetch (opcode and address from instruction memory),
// then operand read from data memory, both synchronous RAMs, then execute,
// which registers the result. A new cmd can be taken, and its fetch issued
// from the new PC, in the execute cycle of the item before it, unless rsp is
// stalled with the output register full.
// The result sits in an output register, so the next cmd is taken while it
// waits; while rsp_stall holds and the register is full, the item in execute
// waits there and cmd_stall stays high.
// Reset clears PC, accumulator, halt flag and data memory (valid bits, no
// clearing pass); instruction memory is undefined until written. Data
// addresses use the low address bits; depths are powers of two.
module accumulator_cpu_step import acm_pkg::*; #(
    parameter int PROG_DEPTH = PROG_DEPTH_DEF,
    parameter int DATA_DEPTH = DATA_DEPTH_DEF,
    parameter int WORD_BITS  = WORD_BITS_DEF
) (
    input  logic clk,
    input  logic rst_n,
    input  cmd_t cmd,
    input  logic cmd_valid,
    output logic cmd_stall,
    output rsp_t rsp,
    output logic rsp_valid,
    input  logic rsp_stall
);

    localparam int PAW = $clog2(PROG_DEPTH);
    localparam int DAW = $clog2(DATA_DEPTH);

    typedef enum logic [1:0] {ST_IDLE, ST_DATA, ST_EXEC} state_t;

    state_t                state_reg;
    state_t                state_next;
    logic [PAW-1:0]        pc_reg;
    logic [WORD_BITS-1:0]  acc_reg;
    logic                  halted_reg;
    rsp_t                  rsp_reg;
    logic                  rsp_valid_reg;
    logic                  kind_reg;
    logic signed [31:0]    in_value_reg;

    logic                  accept;
    logic                  can_finish;
    logic                  finish;
    logic                  prog_wr;
    logic [PAW-1:0]        fetch_pc;
    logic [PAW-1:0]        fetch_pc_arg;
    logic [7:0]            opc_word;
    logic [7:0]            adr_word;
    logic [WORD_BITS-1:0]  dm_rdata;
    logic                  exec;
    logic [PAW-1:0]        pc_next;
    logic [WORD_BITS-1:0]  acc_next;
    alu_flags_t            flags;

    assign can_finish = !rsp_valid_reg || !rsp_stall;
    assign finish     = (state_reg == ST_EXEC) && can_finish;
    assign cmd_stall  = !((state_reg == ST_IDLE) || finish);
    assign accept     = cmd_valid && !cmd_stall;
    assign prog_wr    = accept && (cmd.op_kind == KIND_PROG);

    // next fetch goes out in the execute cycle, from the updated PC
    assign fetch_pc     = finish ? pc_next : pc_reg;
    assign fetch_pc_arg = fetch_pc + PAW'(1);

    assign exec = (kind_reg == KIND_EXEC) && !halted_reg;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_DATA;
                end
            end
            ST_DATA:
            begin
                state_next = ST_EXEC;
            end
            ST_EXEC:
            begin
                if (accept)
                begin
                    state_next = ST_DATA;
                end
                else if (finish)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            pc_reg        <= '0;
            acc_reg       <= '0;
            halted_reg    <= 1'b0;
            rsp_valid_reg <= 1'b0;
            rsp_reg       <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (finish)
            begin
                pc_reg              <= pc_next;
                acc_reg             <= acc_next;
                halted_reg          <= flags.halt_next;
                rsp_valid_reg       <= 1'b1;
                rsp_reg.pc_now      <= 7'(pc_next);
                rsp_reg.acc_now     <= 32'(acc_next);
                rsp_reg.out_valid   <= flags.strobe;
                rsp_reg.done_opcode <= flags.done;
                rsp_reg.halted_now  <= flags.halt_next;
            end
            else if (!rsp_stall)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            kind_reg     <= cmd.op_kind;
            in_value_reg <= cmd.in_value;
        end
    end

    // two copies of the program so opcode and address come out together
    acm_ram #(
        .WIDTH (8),
        .DEPTH (PROG_DEPTH)
    ) u_imem_op (
        .clk     (clk),
        .wr_en   (prog_wr),
        .wr_addr (PAW'(cmd.prog_index)),
        .wr_data (cmd.prog_word),
        .rd_en   (accept),
        .rd_addr (fetch_pc),
        .rd_data (opc_word)
    );

    acm_ram #(
        .WIDTH (8),
        .DEPTH (PROG_DEPTH)
    ) u_imem_arg (
        .clk     (clk),
        .wr_en   (prog_wr),
        .wr_addr (PAW'(cmd.prog_index)),
        .wr_data (cmd.prog_word),
        .rd_en   (accept),
        .rd_addr (fetch_pc_arg),
        .rd_data (adr_word)
    );

    acm_dmem #(
        .WIDTH (WORD_BITS),
        .DEPTH (DATA_DEPTH)
    ) u_dmem (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (finish && flags.st_en),
        .wr_addr (DAW'(adr_word)),
        .wr_data (acc_reg),
        .rd_en   (state_reg == ST_DATA),
        .rd_addr (DAW'(adr_word)),
        .rd_data (dm_rdata)
    );

    acm_alu #(
        .PAW       (PAW),
        .WORD_BITS (WORD_BITS)
    ) u_alu (
        .exec     (exec),
        .opc      (opc_word),
        .adr      (adr_word),
        .pc       (pc_reg),
        .acc      (acc_reg),
        .halted   (halted_reg),
        .mem_data (dm_rdata),
        .in_value (in_value_reg),
        .pc_next  (pc_next),
        .acc_next (acc_next),
        .flags    (flags)
    );

    assign rsp       = rsp_reg;
    assign rsp_valid = rsp_valid_reg;

endmodule

>>> rtl/core/acm_checker.sv
`timescale 1ns / 1ps

module acm_checker import acm_pkg::*; (
    input logic clk,
    input logic rst_n,
    input logic cmd_valid,
    input logic cmd_stall,
    input rsp_t rsp,
    input logic rsp_valid,
    input logic rsp_stall
);

    logic halt_seen_reg;
    logic rsp_xfer;

    assign rsp_xfer = rsp_valid && !rsp_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            halt_seen_reg <= 1'b0;
        end
        else if (rsp_xfer && rsp.halted_now)
        begin
            halt_seen_reg <= 1'b1;
        end
    end

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
        else $error("rsp dropped or changed while stalled");

    a_halt_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_xfer && halt_seen_reg |->
            rsp.halted_now && (rsp.done_opcode == 4'd0) && !rsp.out_valid)
        else $error("activity after halt");

    a_out_opcode: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.out_valid |-> rsp.done_opcode == OP_OUT[3:0])
        else $error("out strobe without OUT opcode");

    a_cmd_spacing: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && !cmd_stall |=> cmd_stall)
        else $error("cmd taken in the cycle after a transfer");

endmodule

bind accumulator_cpu_step acm_checker u_acm_checker (.*);

>>> test/accumulator_cpu_step_tb.sv
`timescale 1ns / 1ps

module accumulator_cpu_step_tb;
    import acm_pkg::*;

    localparam int PLAN = 0;   // copy walked by the stimulus generator
    localparam int LIVE = 1;   // copy advanced on each accepted cmd transfer
    localparam int STALL_LIMIT = 5000;
    localparam int IDLE_PCT = 19;
    localparam int ITEM_TARGET = 550;

    logic clk;
    logic rst_n = 1'b0;
    cmd_t cmd = '0;
    logic cmd_valid = 1'b0;
    logic cmd_stall;
    rsp_t rsp;
    logic rsp_valid;
    logic rsp_stall = 1'b0;

    accumulator_cpu_step DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .rsp       (rsp),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall)
    );

    // machine state, two copies
    logic [7:0]         core_imem [2][128];
    logic [31:0]        core_dmem [2][16];
    logic [6:0]         core_pc   [2];
    logic signed [31:0] core_acc  [2];
    bit                 core_halt [2];

    bit   written_mask [128];
    bit   allow_halt;
    cmd_t cmd_backlog [$];
    rsp_t pending_status [$];
    int   stim_total;
    int   accepted_cmds = 0;
    int   prog_writes = 0;
    int   exec_steps = 0;
    int   out_strobes = 0;
    int   halts_seen = 0;
    int   results_seen = 0;
    int   fail_count = 0;
    int   quiet_cycles = 0;
    bit   calm;

    // no idling on either side for a stretch in the middle of the run
    assign calm = (accepted_cmds >= 250) && (accepted_cmds < 350);

    function automatic rsp_t run_item(input int w, input cmd_t c);
        rsp_t       r;
        logic [7:0] opc;
        logic [7:0] adr;
        logic [6:0] nxt;
        bit         is_zero;
        bit         is_neg;
        r = '0;
        if (c.op_kind == KIND_PROG) begin
            core_imem[w][c.prog_index] = c.prog_word;
        end
        else if (!core_halt[w]) begin
            nxt = core_pc[w] + 7'd1;
            opc = core_imem[w][core_pc[w]];
            adr = core_imem[w][nxt];
            is_zero = (core_acc[w] == 32'sd0);
            is_neg = core_acc[w][31];
            core_pc[w] = core_pc[w] + 7'd2;
            if (opc >= OP_LOAD && opc <= OP_SKIPL)
                r.done_opcode = opc[3:0];
            case (opc)
                OP_LOAD:  core_acc[w] = core_dmem[w][adr[3:0]];
                OP_ADD:   core_acc[w] = core_acc[w] + core_dmem[w][adr[3:0]];
                OP_STORE: core_dmem[w][adr[3:0]] = core_acc[w];
                OP_SUB:   core_acc[w] = core_acc[w] - core_dmem[w][adr[3:0]];
                OP_IN:    core_acc[w] = c.in_value;
                OP_OUT:   r.out_valid = 1'b1;
                OP_HALT:  core_halt[w] = 1'b1;
                OP_JMP:   core_pc[w] = adr[6:0];
                OP_SKIPZ: if (is_zero) core_pc[w] = core_pc[w] + 7'd2;
                OP_SKIPG: if (!is_zero && !is_neg) core_pc[w] = core_pc[w] + 7'd2;
                OP_SKIPL: if (is_neg) core_pc[w] = core_pc[w] + 7'd2;
                default: ;
            endcase
        end
        r.pc_now = core_pc[w];
        r.acc_now = core_acc[w];
        r.halted_now = core_halt[w];
        return r;
    endfunction

    function automatic logic [31:0] pick_value();
        int sel;
        sel = $urandom_range(99);
        if (sel < 12)
            return 32'h0000_0000;
        else if (sel < 17)
            return 32'h7fff_ffff;
        else if (sel < 22)
            return 32'h8000_0000;
        else if (sel < 30)
            return -$urandom_range(1, 8);
        else if (sel < 38)
            return $urandom_range(1, 8);
        return $urandom;
    endfunction

    // valid opcodes mostly, HALT never; unknown ones now and then
    function automatic logic [7:0] pick_opcode();
        int sel;
        sel = $urandom_range(99);
        if (sel < 5)
            return 8'd0;
        else if (sel < 12)
            return 8'($urandom_range(12, 255));
        sel = $urandom_range(9);
        return (sel >= 6) ? 8'(sel + 2) : 8'(sel + 1);
    endfunction

    function automatic logic [7:0] pick_addr();
        if ($urandom_range(99) < 75)
            return 8'($urandom_range(15));
        return 8'($urandom_range(255));
    endfunction

    task automatic queue_cmd(input cmd_t c);
        void'(run_item(PLAN, c));
        cmd_backlog.push_back(c);
    endtask

    task automatic write_word(input logic [6:0] idx, input logic [7:0] word);
        cmd_t c;
        c.op_kind = KIND_PROG;
        c.prog_index = idx;
        c.prog_word = word;
        c.in_value = $urandom;
        written_mask[idx] = 1'b1;
        queue_cmd(c);
    endtask

    // an exec never fetches an unwritten word, and HALT only when allowed
    task automatic step(input logic [31:0] val);
        cmd_t       c;
        logic [6:0] p;
        logic [6:0] nx;
        p = core_pc[PLAN];
        nx = p + 7'd1;
        if (!core_halt[PLAN]) begin
            if (!written_mask[p] || (!allow_halt && core_imem[PLAN][p] == OP_HALT))
                write_word(p, pick_opcode());
            if (!written_mask[nx])
                write_word(nx, 8'($urandom_range(255)));
        end
        c.op_kind = KIND_EXEC;
        c.prog_index = 7'($urandom_range(127));
        c.prog_word = 8'($urandom_range(255));
        c.in_value = val;
        queue_cmd(c);
    endtask

    task automatic build_stimulus();
        int         n;
        int         sel;
        logic [6:0] base;
        logic [7:0] op;
        allow_halt = 1'b0;

        // directed: overflow on ADD, OUT, taken SKIPL, JMP with a wide target,
        // fetch across the top of program memory, unknown opcodes
        write_word(7'd0, OP_IN);     write_word(7'd1, 8'd0);
        write_word(7'd2, OP_STORE);  write_word(7'd3, 8'd19);
        write_word(7'd4, OP_ADD);    write_word(7'd5, 8'd3);
        write_word(7'd6, OP_OUT);    write_word(7'd7, 8'd0);
        write_word(7'd8, OP_SKIPL);  write_word(7'd9, 8'd0);
        write_word(7'd12, OP_JMP);   write_word(7'd13, 8'd255);
        write_word(7'd127, OP_LOAD);
        step(32'h7fff_ffff);
        repeat (9) step(pick_value());

        while (cmd_backlog.size() < ITEM_TARGET) begin
            sel = $urandom_range(99);
            if (sel < 70) begin
                // short program at the current PC, then run it
                n = $urandom_range(2, 6);
                base = core_pc[PLAN];
                for (int i = 0; i < n; i++) begin
                    op = pick_opcode();
                    write_word(base + 7'(2 * i), op);
                    write_word(base + 7'(2 * i + 1),
                               (op == OP_JMP) ? 8'($urandom_range(255)) : pick_addr());
                end
                repeat ($urandom_range(n, n + 2)) step(pick_value());
            end
            else if (sel < 90) begin
                write_word(7'($urandom_range(127)), 8'($urandom_range(255)));
            end
            else begin
                step(pick_value());
            end
        end

        // halt last: steps after it change nothing, writes are still taken
        allow_halt = 1'b1;
        write_word(core_pc[PLAN], OP_HALT);
        step(pick_value());
        step(pick_value());
        write_word(7'($urandom_range(127)), pick_opcode());
        repeat (3) step(pick_value());
        stim_total = cmd_backlog.size();
    endtask

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_valid <= 1'b0;
            cmd <= '0;
        end
        else
        begin
            if (cmd_valid && !cmd_stall)
            begin
                pending_status.push_back(run_item(LIVE, cmd));
                accepted_cmds++;
                if (cmd.op_kind == KIND_PROG)
                    prog_writes++;
                else
                    exec_steps++;
            end
            if (!cmd_valid || !cmd_stall)
            begin
                if (cmd_backlog.size() > 0 && (calm || $urandom_range(99) >= IDLE_PCT))
                begin
                    cmd <= cmd_backlog.pop_front();
                    cmd_valid <= 1'b1;
                end
                else
                    cmd_valid <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge clk or negedge rst_n)
    begin
        rsp_t want;
        if (!rst_n)
            rsp_stall <= 1'b0;
        else
        begin
            if (rsp_valid && !rsp_stall)
            begin
                results_seen++;
                if (rsp.out_valid)
                    out_strobes++;
                if (rsp.done_opcode == OP_HALT[3:0])
                    halts_seen++;
                if (pending_status.size() == 0)
                begin
                    $error("rsp transfer with nothing expected: %h", rsp);
                    fail_count++;
                end
                else
                begin
                    want = pending_status.pop_front();
                    if (rsp.pc_now !== want.pc_now)
                    begin
                        $error("pc_now: expected %0d, got %0d", want.pc_now, rsp.pc_now);
                        fail_count++;
                    end
                    if (rsp.acc_now !== want.acc_now)
                    begin
                        $error("acc_now: expected %h, got %h", want.acc_now, rsp.acc_now);
                        fail_count++;
                    end
                    if (rsp.out_valid !== want.out_valid)
                    begin
                        $error("out_valid: expected %0b, got %0b",
                               want.out_valid, rsp.out_valid);
                        fail_count++;
                    end
                    if (rsp.done_opcode !== want.done_opcode)
                    begin
                        $error("done_opcode: expected %0d, got %0d",
                               want.done_opcode, rsp.done_opcode);
                        fail_count++;
                    end
                    if (rsp.halted_now !== want.halted_now)
                    begin
                        $error("halted_now: expected %0b, got %0b",
                               want.halted_now, rsp.halted_now);
                        fail_count++;
                    end
                end
            end
            rsp_stall <= !calm && ($urandom_range(99) < IDLE_PCT);
        end
    end

    // watchdog: cycles with no transfer on either channel
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((cmd_valid && !cmd_stall) || (rsp_valid && !rsp_stall))
                quiet_cycles <= 0;
            else if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("timeout: no transfer for %0d cycles", STALL_LIMIT);
                $display("CHECKS FAILED");
                $finish;
            end
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial
    begin
        for (int w = 0; w < 2; w++)
        begin
            foreach (core_imem[w][i]) core_imem[w][i] = 8'd0;
            foreach (core_dmem[w][i]) core_dmem[w][i] = 32'd0;
            core_pc[w] = 7'd0;
            core_acc[w] = 32'sd0;
            core_halt[w] = 1'b0;
        end
        foreach (written_mask[i]) written_mask[i] = 1'b0;
        build_stimulus();

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        while (accepted_cmds < stim_total || pending_status.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        $display("covered %0d cmd transfers: %0d program writes, %0d steps",
                 accepted_cmds, prog_writes, exec_steps);
        $display("checked %0d results, %0d OUT strobes, %0d HALT executed",
                 results_seen, out_strobes, halts_seen);
        if (fail_count == 0 && pending_status.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
